[src/atan_soft_clip_blend_distortion_unit_defines.svh]
// ---------------------------------------------------------------------------
// atan soft clip unit assertion macros
// concurrent assertion wrappers on clk and rst_n, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef ATAN_SOFT_CLIP_BLEND_DISTORTION_UNIT_DEFINES_SVH
`define ATAN_SOFT_CLIP_BLEND_DISTORTION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[src/atanclip_pkg.sv]
// ---------------------------------------------------------------------------
// atan soft clip package
// formats, register map and cordic angle table shared by the clip unit
// ---------------------------------------------------------------------------
package atanclip_pkg;

    // sample format
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;

    // cordic length and angle table
    localparam int ATAN_STEPS = 20;
    localparam int TABLE_LEN  = 32;
    localparam int WORK_BITS  = 32;

    // register widths
    localparam int DRIVE_BITS = 16;
    localparam int GAIN_BITS  = 11;
    localparam int DR_BITS    = DRIVE_BITS + GAIN_BITS;

    // register map
    localparam int REG_IDX_BITS = 2;
    localparam int PADDR_BITS   = REG_IDX_BITS + 2;
    localparam int PDATA_BITS   = 32;

    localparam logic [REG_IDX_BITS-1:0] REG_DRIVE_GAIN  = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_RANGE_GAIN  = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_BLEND_MIX   = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_VOLUME_GAIN = 2'd3;

    localparam logic [DRIVE_BITS-1:0] DRIVE_RESET  = 16'd205;
    localparam logic [GAIN_BITS-1:0]  RANGE_RESET  = 11'd922;
    localparam logic [GAIN_BITS-1:0]  BLEND_RESET  = 11'd512;
    localparam logic [GAIN_BITS-1:0]  VOLUME_RESET = 11'd512;
    localparam logic [DR_BITS-1:0]    DR_RESET     = DR_BITS'(205 * 922);

    // drive product x * drive * range, scaled down to q.32
    // drive and range together carry 20 fraction bits
    localparam int PROD_BITS = SAMPLE_BITS + DR_BITS;
    localparam int U_SHIFT   = FRAC_BITS + 20 - WORK_BITS;
    localparam int U_BITS    = PROD_BITS - U_SHIFT;

    // cordic datapath
    localparam int CORDIC_BITS = U_BITS + 3;
    localparam int Z_BITS      = WORK_BITS + 2;
    localparam logic signed [CORDIC_BITS-1:0] CORDIC_X0 = CORDIC_BITS'(1) << WORK_BITS;

    // blend and volume
    localparam int WEIGHT_BITS = GAIN_BITS + 1;
    localparam logic [WEIGHT_BITS-1:0] UNITY_WEIGHT = WEIGHT_BITS'(1024);
    localparam int XS_SHIFT = WORK_BITS - FRAC_BITS;
    localparam int XS_BITS  = SAMPLE_BITS + XS_SHIFT;
    localparam int PC_BITS  = Z_BITS + GAIN_BITS;
    localparam int PX_BITS  = XS_BITS + WEIGHT_BITS;
    localparam int MIX_BITS = PC_BITS + 1;
    localparam int VOL_BITS = MIX_BITS + GAIN_BITS;

    // final halving and rounding
    localparam int RND_SHIFT = 53 - FRAC_BITS;
    localparam int Y_BITS    = VOL_BITS - RND_SHIFT;
    localparam logic signed [VOL_BITS-1:0] RND_HALF = VOL_BITS'(1) << (RND_SHIFT - 1);
    localparam logic signed [Y_BITS-1:0] Y_HI =
        {{(Y_BITS - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
    localparam logic signed [Y_BITS-1:0] Y_LO =
        {{(Y_BITS - FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};

    // atan(2^-i) in units of pi/2 scaled by 2^32, truncated
    localparam logic [WORK_BITS-1:0] ANGLE_TABLE [TABLE_LEN] = '{
        32'd2147483648, 32'd1267733622, 32'd669835629,  32'd340019024,
        32'd170669324,  32'd85417861,   32'd42719353,   32'd21360980,
        32'd10680653,   32'd5340346,    32'd2670176,    32'd1335088,
        32'd667544,     32'd333772,     32'd166886,     32'd83443,
        32'd41721,      32'd20860,      32'd10430,      32'd5215,
        32'd2607,       32'd1303,       32'd651,        32'd325,
        32'd162,        32'd81,         32'd40,         32'd20,
        32'd10,         32'd5,          32'd2,          32'd1
    };

endpackage

[src/atan_soft_clip_blend_distortion_unit.sv]
// ---------------------------------------------------------------------------
// atan soft clip blend distortion unit
// scales each sample by drive and range, soft clips it with (2/pi)*atan by a
// pipelined vectoring cordic, cross-fades clipped and clean, halves, applies
// volume and rounds back to the sample format
// ---------------------------------------------------------------------------
//
//   channel   handshake                 payload
//   -------   -----------------------   -------------------------
//   input     in_valid / in_ready       sample_in
//   output    out_valid / out_ready     sample_out
//   config    psel/penable/pwrite       paddr, pwdata -> prdata
//
// one request per cycle while the output is not stalled; each result passes through
// 25 register stages: one drive multiply stage, one stage per cordic step
// (ATAN_STEPS), two blend stages, one volume stage and the rounding output
// register
// all stages advance together whenever the output register is empty or taken,
// so a stall freezes the whole pipeline and nothing is dropped or repeated
// reset clears the stage valid bits and loads the register defaults
//
`include "atan_soft_clip_blend_distortion_unit_defines.svh"

module atan_soft_clip_blend_distortion_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [atanclip_pkg::SAMPLE_BITS-1:0] sample_in,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [atanclip_pkg::SAMPLE_BITS-1:0] sample_out,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [atanclip_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [atanclip_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [atanclip_pkg::PDATA_BITS-1:0]  prdata,
    output logic                                 pready
);

    localparam int SB    = atanclip_pkg::SAMPLE_BITS;
    localparam int STEPS = atanclip_pkg::ATAN_STEPS;
    localparam int CW    = atanclip_pkg::CORDIC_BITS;
    localparam int ZB    = atanclip_pkg::Z_BITS;
    localparam int GB    = atanclip_pkg::GAIN_BITS;
    localparam int DB    = atanclip_pkg::DRIVE_BITS;

    // configuration registers
    logic [DB-1:0]                        drive_reg;
    logic [GB-1:0]                        range_reg;
    logic [GB-1:0]                        blend_reg;
    logic [GB-1:0]                        volume_reg;
    logic [atanclip_pkg::DR_BITS-1:0]     dr_reg;
    logic [atanclip_pkg::DR_BITS-1:0]     dr_next;
    logic                                 cfg_write;
    logic [atanclip_pkg::REG_IDX_BITS-1:0] cfg_idx;

    // pipeline control
    logic                                 advance;
    logic                                 s1_valid_reg;
    logic [STEPS-1:0]                     cv_reg;
    logic                                 m1_valid_reg;
    logic                                 m2_valid_reg;
    logic                                 m3_valid_reg;
    logic                                 out_valid_reg;

    // pipeline payload
    logic signed [SB-1:0]                          s1_x_reg;
    logic signed [atanclip_pkg::PROD_BITS-1:0]     s1_prod_reg;
    logic signed [atanclip_pkg::PROD_BITS-1:0]     s1_prod_next;
    logic signed [atanclip_pkg::U_BITS-1:0]        u_val;
    logic signed [CW-1:0]                          cx_reg [STEPS];
    logic signed [CW-1:0]                          cy_reg [STEPS];
    logic signed [ZB-1:0]                          cz_reg [STEPS];
    logic signed [SB-1:0]                          cs_reg [STEPS];
    logic signed [CW-1:0]                          cx_next [STEPS];
    logic signed [CW-1:0]                          cy_next [STEPS];
    logic signed [ZB-1:0]                          cz_next [STEPS];
    logic signed [atanclip_pkg::PC_BITS-1:0]       m1_pc_reg;
    logic signed [atanclip_pkg::PC_BITS-1:0]       m1_pc_next;
    logic signed [atanclip_pkg::PX_BITS-1:0]       m1_px_reg;
    logic signed [atanclip_pkg::PX_BITS-1:0]       m1_px_next;
    logic signed [atanclip_pkg::MIX_BITS-1:0]      m2_mix_reg;
    logic signed [atanclip_pkg::MIX_BITS-1:0]      m2_mix_next;
    logic signed [atanclip_pkg::VOL_BITS-1:0]      m3_vol_reg;
    logic signed [atanclip_pkg::VOL_BITS-1:0]      m3_vol_next;
    logic signed [SB-1:0]                          sample_out_reg;
    logic signed [SB-1:0]                          sample_out_next;

    logic signed [atanclip_pkg::XS_BITS-1:0]       x_scaled;
    logic signed [atanclip_pkg::WEIGHT_BITS-1:0]   clean_weight;
    logic signed [atanclip_pkg::VOL_BITS-1:0]      rounded;
    logic signed [atanclip_pkg::Y_BITS-1:0]        y_full;

    // apb decode
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[atanclip_pkg::PADDR_BITS-1:2];

    // drive times range, kept up to date with each drive or range write
    always_comb
    begin
        dr_next = dr_reg;
        if (cfg_write && (cfg_idx == atanclip_pkg::REG_DRIVE_GAIN))
        begin
            dr_next = atanclip_pkg::DR_BITS'(pwdata[DB-1:0])
                    * atanclip_pkg::DR_BITS'(range_reg);
        end
        else if (cfg_write && (cfg_idx == atanclip_pkg::REG_RANGE_GAIN))
        begin
            dr_next = atanclip_pkg::DR_BITS'(drive_reg)
                    * atanclip_pkg::DR_BITS'(pwdata[GB-1:0]);
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg  <= atanclip_pkg::DRIVE_RESET;
            range_reg  <= atanclip_pkg::RANGE_RESET;
            blend_reg  <= atanclip_pkg::BLEND_RESET;
            volume_reg <= atanclip_pkg::VOLUME_RESET;
            dr_reg     <= atanclip_pkg::DR_RESET;
        end
        else
        begin
            dr_reg <= dr_next;
            if (cfg_write)
            begin
                case (cfg_idx)
                    atanclip_pkg::REG_DRIVE_GAIN:  drive_reg  <= pwdata[DB-1:0];
                    atanclip_pkg::REG_RANGE_GAIN:  range_reg  <= pwdata[GB-1:0];
                    atanclip_pkg::REG_BLEND_MIX:   blend_reg  <= pwdata[GB-1:0];
                    atanclip_pkg::REG_VOLUME_GAIN: volume_reg <= pwdata[GB-1:0];
                    default:                       drive_reg  <= drive_reg;
                endcase
            end
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            atanclip_pkg::REG_DRIVE_GAIN:  prdata = atanclip_pkg::PDATA_BITS'(drive_reg);
            atanclip_pkg::REG_RANGE_GAIN:  prdata = atanclip_pkg::PDATA_BITS'(range_reg);
            atanclip_pkg::REG_BLEND_MIX:   prdata = atanclip_pkg::PDATA_BITS'(blend_reg);
            atanclip_pkg::REG_VOLUME_GAIN: prdata = atanclip_pkg::PDATA_BITS'(volume_reg);
            default:                       prdata = '0;
        endcase
    end

    // global stall: everything moves when the output slot frees up
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = out_valid_reg;
    assign sample_out = sample_out_reg;

    // drive multiply on the incoming sample
    assign s1_prod_next = atanclip_pkg::PROD_BITS'(sample_in)
                        * atanclip_pkg::PROD_BITS'($signed({1'b0, dr_reg}));

    // drive product in q.32
    assign u_val = atanclip_pkg::U_BITS'(s1_prod_reg >>> atanclip_pkg::U_SHIFT);

    // vectoring cordic, one step per stage
    for (genvar k = 0; k < STEPS; k++)
    begin : g_cordic
        localparam logic signed [ZB-1:0] STEP_ANGLE =
            ZB'(atanclip_pkg::ANGLE_TABLE[k % atanclip_pkg::TABLE_LEN]);

        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [ZB-1:0] z_in;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        if (k == 0)
        begin : g_first
            assign x_in = atanclip_pkg::CORDIC_X0;
            assign y_in = CW'(u_val);
            assign z_in = '0;
        end
        else
        begin : g_rest
            assign x_in = cx_reg[k-1];
            assign y_in = cy_reg[k-1];
            assign z_in = cz_reg[k-1];
        end

        assign dx = y_in >>> k;
        assign dy = x_in >>> k;

        // rotate toward y = 0 and accumulate the angle
        assign cx_next[k] = y_in[CW-1] ? (x_in - dx) : (x_in + dx);
        assign cy_next[k] = y_in[CW-1] ? (y_in + dy) : (y_in - dy);
        assign cz_next[k] = y_in[CW-1] ? (z_in - STEP_ANGLE) : (z_in + STEP_ANGLE);
    end

    // blend products: clipped times blend, clean times (1 - blend)
    assign x_scaled     = {cs_reg[STEPS-1], {atanclip_pkg::XS_SHIFT{1'b0}}};
    assign clean_weight = $signed(atanclip_pkg::UNITY_WEIGHT
                        - atanclip_pkg::WEIGHT_BITS'(blend_reg));
    assign m1_pc_next = atanclip_pkg::PC_BITS'(cz_reg[STEPS-1])
                      * atanclip_pkg::PC_BITS'($signed({1'b0, blend_reg}));
    assign m1_px_next = atanclip_pkg::PX_BITS'(x_scaled)
                      * atanclip_pkg::PX_BITS'(clean_weight);

    // blend sum
    assign m2_mix_next = atanclip_pkg::MIX_BITS'(m1_pc_reg)
                       + atanclip_pkg::MIX_BITS'(m1_px_reg);

    // volume
    assign m3_vol_next = atanclip_pkg::VOL_BITS'(m2_mix_reg)
                       * atanclip_pkg::VOL_BITS'($signed({1'b0, volume_reg}));

    // halve, round to nearest with ties up, saturate
    assign rounded = m3_vol_reg + atanclip_pkg::RND_HALF;
    assign y_full  = atanclip_pkg::Y_BITS'(rounded >>> atanclip_pkg::RND_SHIFT);

    always_comb
    begin
        if (y_full > atanclip_pkg::Y_HI)
        begin
            sample_out_next = atanclip_pkg::Y_HI[SB-1:0];
        end
        else if (y_full < atanclip_pkg::Y_LO)
        begin
            sample_out_next = atanclip_pkg::Y_LO[SB-1:0];
        end
        else
        begin
            sample_out_next = y_full[SB-1:0];
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            cv_reg        <= '0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            cv_reg        <= {cv_reg[STEPS-2:0], s1_valid_reg};
            m1_valid_reg  <= cv_reg[STEPS-1];
            m2_valid_reg  <= m1_valid_reg;
            m3_valid_reg  <= m2_valid_reg;
            out_valid_reg <= m3_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x_reg    <= sample_in;
            s1_prod_reg <= s1_prod_next;
            for (int k = 0; k < STEPS; k++)
            begin
                cx_reg[k] <= cx_next[k];
                cy_reg[k] <= cy_next[k];
                cz_reg[k] <= cz_next[k];
                if (k == 0)
                begin
                    cs_reg[k] <= s1_x_reg;
                end
                else
                begin
                    cs_reg[k] <= cs_reg[k-1];
                end
            end
            m1_pc_reg      <= m1_pc_next;
            m1_px_reg      <= m1_px_next;
            m2_mix_reg     <= m2_mix_next;
            m3_vol_reg     <= m3_vol_next;
            sample_out_reg <= sample_out_next;
        end
    end

    // checks
    `ASSERT_NEXT(a_accept_enters, in_valid && in_ready, s1_valid_reg, "accepted request lost at entry")
    `ASSERT_NEXT(a_stall_freezes, !advance, $stable(cv_reg) && $stable(m3_valid_reg) && out_valid_reg, "stall changed pipeline occupancy")
    `ASSERT_IMPLY(a_cordic_x_positive, cv_reg[STEPS-1], !cx_reg[STEPS-1][CW-1], "cordic x went negative")
    `ASSERT_IMPLY(a_out_from_pipe, $rose(out_valid_reg), $past(m3_valid_reg), "result without a request behind it")

endmodule
